/* rtl/spn_pkg.sv */
// spn_pkg: shared types, constants, s-box tables and a byte helper function for the spn cipher
// no dependencies
package spn_pkg;

  localparam int ROUNDS     = 14;
  localparam int BLK_W      = 128;
  localparam int PADDR_W    = 4;

  typedef logic [BLK_W-1:0] blk_t;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_t;

  typedef enum logic [PADDR_W-1:0] {
    REG_KEY_HIGH = 4'h0,
    REG_KEY_LOW  = 4'h8
  } reg_addr_t;

  // per-stage payload travelling down the round pipeline
  typedef struct packed {
    op_t  op;
    blk_t blk;
  } stage_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  // byte n of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input blk_t b, input int n);
    return b[BLK_W-1-8*n -: 8];
  endfunction

endpackage

/* rtl/spn_round.sv */
// spn_round: one registered cipher round, encrypt or decrypt per item
// depends on spn_pkg
module spn_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  spn_pkg::stage_t in_data,
  input  spn_pkg::blk_t   key,
  output logic            out_valid,
  output spn_pkg::stage_t out_data
);
  import spn_pkg::*;

  blk_t enc_blk;
  blk_t dec_blk;

  always_comb begin
    enc_blk = '0;
    dec_blk = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        enc_blk[BLK_W-1-8*(4*r+c) -: 8] =
          FWD_SBOX[get_byte(in_data.blk, 4*((r+c)%4)+c)] ^ get_byte(key, 4*r+c);
        dec_blk[BLK_W-1-8*(4*r+c) -: 8] =
          INV_SBOX[get_byte(in_data.blk, 4*((r+4-c)%4)+c)
                   ^ get_byte(key, 4*((r+4-c)%4)+c)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.op  <= in_data.op;
      out_data.blk <= (in_data.op == OP_DEC) ? dec_blk : enc_blk;
    end
  end
endmodule

/* rtl/spn_cfg.sv */
// spn_cfg: apb key registers
// depends on spn_pkg
module spn_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spn_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output spn_pkg::blk_t               key
);
  import spn_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr) begin
      if (paddr == REG_KEY_HIGH) key_high <= pwdata;
      if (paddr == REG_KEY_LOW)  key_low  <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_KEY_HIGH) prdata = key_high;
    if (paddr == REG_KEY_LOW)  prdata = key_low;
  end

  assign key = {key_high, key_low};
endmodule

/* rtl/spn_block_cipher_enc_dec_top.sv */
// spn_block_cipher_enc_dec_top: 14-round spn cipher, one round per pipeline stage
// depends on spn_pkg, spn_cfg, spn_round
//
//   channel   dir  payload
//   s_axis    in   tuser opcode, tdata block
//   m_axis    out  tdata result
//   apb       in   key_high at 0x0, key_low at 0x8
//
// one block per cycle while the output is not stalled; the last round register drives the output
// the 14 round stages advance together when the last stage is free or being
// taken, so a stall freezes all of them in place
// reset clears the valid bits and the key registers to zero
module spn_block_cipher_enc_dec_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [127:0]                s_axis_tdata,  // block_low, block_high
  input  logic                        s_axis_tuser,  // opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [127:0]                m_axis_tdata,  // result_low, result_high
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spn_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import spn_pkg::*;

  blk_t   key;
  logic   adv;
  logic   vld [ROUNDS+1];
  stage_t stg [ROUNDS+1];

  assign pready = 1'b1;

  spn_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .key
  );

  // whole pipe moves when the last stage is empty or draining
  assign adv           = !vld[ROUNDS] || m_axis_tready;
  assign s_axis_tready = adv;

  assign vld[0]     = s_axis_tvalid;
  assign stg[0].op  = op_t'(s_axis_tuser);
  assign stg[0].blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
    spn_round u_round (
      .clk, .rst, .en(adv),
      .in_valid(vld[g]), .in_data(stg[g]), .key,
      .out_valid(vld[g+1]), .out_data(stg[g+1])
    );
  end

  assign m_axis_tvalid = vld[ROUNDS];
  assign m_axis_tdata  = {stg[ROUNDS].blk[63:0], stg[ROUNDS].blk[127:64]};
endmodule

/* rtl/spn_checker.sv */
// spn_checker: port-level checks on the spn cipher top level
// depends on spn_block_cipher_enc_dec_top (bound below)
module spn_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         pready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipe frozen");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("valid after reset");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind spn_block_cipher_enc_dec_top spn_checker u_chk (.*);
